### rtl/icfa_pkg.sv
//------------------------------------------------------------------------------
// Integer constant fold ALU package
// Transfer types, operation, condition and status codes shared by the design.
//------------------------------------------------------------------------------
`default_nettype none

package icfa_pkg;

   // Operation codes.
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_SUB   = 5'd1;
   localparam logic [4:0] OP_DIV   = 5'd2;
   localparam logic [4:0] OP_REM   = 5'd3;
   localparam logic [4:0] OP_UDIV  = 5'd4;
   localparam logic [4:0] OP_UREM  = 5'd5;
   localparam logic [4:0] OP_MUL   = 5'd6;
   localparam logic [4:0] OP_AND   = 5'd7;
   localparam logic [4:0] OP_OR    = 5'd8;
   localparam logic [4:0] OP_XOR   = 5'd9;
   localparam logic [4:0] OP_SAR   = 5'd10;
   localparam logic [4:0] OP_SHR   = 5'd11;
   localparam logic [4:0] OP_SHL   = 5'd12;
   localparam logic [4:0] OP_EXTSB = 5'd13;
   localparam logic [4:0] OP_EXTUB = 5'd14;
   localparam logic [4:0] OP_EXTSH = 5'd15;
   localparam logic [4:0] OP_EXTUH = 5'd16;
   localparam logic [4:0] OP_EXTSW = 5'd17;
   localparam logic [4:0] OP_EXTUW = 5'd18;
   localparam logic [4:0] OP_STOSI = 5'd19;
   localparam logic [4:0] OP_DTOSI = 5'd20;
   localparam logic [4:0] OP_CAST  = 5'd21;
   localparam logic [4:0] OP_ICMP  = 5'd22;
   localparam logic [4:0] OP_SCMP  = 5'd23;
   localparam logic [4:0] OP_DCMP  = 5'd24;

   // Integer compare conditions.
   localparam logic [3:0] CI_ULE = 4'd0;
   localparam logic [3:0] CI_ULT = 4'd1;
   localparam logic [3:0] CI_SLE = 4'd2;
   localparam logic [3:0] CI_SLT = 4'd3;
   localparam logic [3:0] CI_SGT = 4'd4;
   localparam logic [3:0] CI_SGE = 4'd5;
   localparam logic [3:0] CI_UGT = 4'd6;
   localparam logic [3:0] CI_UGE = 4'd7;
   localparam logic [3:0] CI_EQ  = 4'd8;
   localparam logic [3:0] CI_NE  = 4'd9;

   // Floating point compare conditions.
   localparam logic [3:0] CF_LE  = 4'd0;
   localparam logic [3:0] CF_LT  = 4'd1;
   localparam logic [3:0] CF_GT  = 4'd2;
   localparam logic [3:0] CF_GE  = 4'd3;
   localparam logic [3:0] CF_NE  = 4'd4;
   localparam logic [3:0] CF_EQ  = 4'd5;
   localparam logic [3:0] CF_ORD = 4'd6;
   localparam logic [3:0] CF_UNO = 4'd7;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFOLD  = 3'd1;
   localparam logic [2:0] ST_ADDADDR = 3'd2;
   localparam logic [2:0] ST_LABDIFF = 3'd3;
   localparam logic [2:0] ST_NUMADDR = 3'd4;
   localparam logic [2:0] ST_BADADDR = 3'd5;

   // Shift amounts are masked to this value.
   localparam logic [5:0] SHIFT_MASK = 6'd63;

   typedef struct packed {
      logic [4:0]         op;
      logic [3:0]         cond;
      logic               wide;
      logic signed [63:0] left_value;
      logic               left_is_addr;
      logic [31:0]        left_label;
      logic signed [63:0] right_value;
      logic               right_is_addr;
      logic [31:0]        right_label;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               result_is_addr;
      logic [31:0]        result_label;
      logic [2:0]         status;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/integer_constant_fold_alu.sv
//------------------------------------------------------------------------------
// Integer constant fold ALU
// Folds one operation on two 64-bit constants, tracking symbol addresses.
//------------------------------------------------------------------------------
// One request enters per cycle unless stalled; its response passes through one
// decode stage, 64 stages of a one-bit-per-stage restoring divider that every
// request passes through, and the output register. The multiplier is split into
// 32x32 partial products summed in the first divider stage. The whole pipeline
// moves as one and holds only while the output register is full and stalled.
`default_nettype none

module integer_constant_fold_alu
   import icfa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] num;
      logic [63:0] den;
   } div_type;

   typedef struct packed {
      logic [4:0]  op;
      logic        wide;
      logic [2:0]  status;
      logic        is_addr;
      logic [31:0] label;
      logic [63:0] value;
      logic        q_neg;
      logic        r_neg;
   } ctrl_type;

   typedef struct packed {
      logic [63:0] p0;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [63:0] fmag;
      logic        fneg;
   } pre_type;

   function automatic logic [63:0] sx32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic logic [31:0] fkey32(input logic [31:0] a);
      logic [31:0] k;
      if (a[30:0] == 31'd0) begin
         k = 32'h8000_0000;
      end else if (a[31]) begin
         k = ~a;
      end else begin
         k = a;
         k[31] = 1'b1;
      end
      return k;
   endfunction

   function automatic logic [63:0] fkey64(input logic [63:0] a);
      logic [63:0] k;
      if (a[62:0] == 63'd0) begin
         k = 64'h8000_0000_0000_0000;
      end else if (a[63]) begin
         k = ~a;
      end else begin
         k = a;
         k[63] = 1'b1;
      end
      return k;
   endfunction

   function automatic div_type div_step(input div_type s);
      logic [64:0] t;
      logic [64:0] d;
      div_type     o;
      t = {s.rem, s.num[63]};
      d = {1'b0, s.den};
      o.den = s.den;
      if (t >= d) begin
         o.rem = 64'(t - d);
         o.num = {s.num[62:0], 1'b1};
      end else begin
         o.rem = t[63:0];
         o.num = {s.num[62:0], 1'b0};
      end
      return o;
   endfunction

   logic     adv;
   logic     valid_ff [0:DIV_STEPS];
   ctrl_type ctrl_ff  [0:DIV_STEPS];
   div_type  div_ff   [0:DIV_STEPS];
   pre_type  pre_ff;
   ctrl_type ctrl_in;
   div_type  div_in;
   pre_type  pre_in;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   ctrl_type ctrl_fix;

   // The pipeline advances unless a finished response is held by the consumer.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode stage: status, address tracking and the operations computed in decode.
   always_comb begin : decode_logic
      logic [63:0] l;
      logic [63:0] r;
      logic        la;
      logic        ra;
      logic [5:0]  sh;
      logic [63:0] ia;
      logic [63:0] ib;
      logic        ult;
      logic        slt;
      logic        ieq;
      logic        icv;
      logic [31:0] ka32;
      logic [31:0] kb32;
      logic [63:0] ka64;
      logic [63:0] kb64;
      logic        un;
      logic        flt;
      logic        feq;
      logic        fgt;
      logic        fcv;
      logic        is_div;
      logic        dzero;
      logic [63:0] sa;
      logic [63:0] sb;
      logic [10:0] ef;
      logic [63:0] mant;
      logic        fspecial;
      logic signed [12:0] ex;
      logic [63:0] minv;
      logic [5:0]  fsh;

      l  = req_data.left_value;
      r  = req_data.right_value;
      la = req_data.left_is_addr;
      ra = req_data.right_is_addr;
      sh = r[5:0] & SHIFT_MASK;

      // Integer compare on the class width.
      ia  = req_data.wide ? l : sx32(l);
      ib  = req_data.wide ? r : sx32(r);
      ult = ia < ib;
      slt = $signed(ia) < $signed(ib);
      ieq = ia == ib;
      unique case (req_data.cond)
         CI_ULE:  icv = ult || ieq;
         CI_ULT:  icv = ult;
         CI_SLE:  icv = slt || ieq;
         CI_SLT:  icv = slt;
         CI_SGT:  icv = !(slt || ieq);
         CI_SGE:  icv = !slt;
         CI_UGT:  icv = !(ult || ieq);
         CI_UGE:  icv = !ult;
         CI_EQ:   icv = ieq;
         CI_NE:   icv = !ieq;
         default: icv = 1'b0;
      endcase

      // Float compare on bit patterns through an order-preserving key.
      ka32 = fkey32(l[31:0]);
      kb32 = fkey32(r[31:0]);
      ka64 = fkey64(l);
      kb64 = fkey64(r);
      if (req_data.op == OP_SCMP) begin
         un  = (l[30:0] > 31'h7F80_0000) || (r[30:0] > 31'h7F80_0000);
         flt = !un && (ka32 < kb32);
         feq = !un && (ka32 == kb32);
         fgt = !un && (ka32 > kb32);
      end else begin
         un  = (l[62:0] > 63'h7FF0_0000_0000_0000) || (r[62:0] > 63'h7FF0_0000_0000_0000);
         flt = !un && (ka64 < kb64);
         feq = !un && (ka64 == kb64);
         fgt = !un && (ka64 > kb64);
      end
      unique case (req_data.cond)
         CF_LE:   fcv = flt || feq;
         CF_LT:   fcv = flt;
         CF_GT:   fcv = fgt;
         CF_GE:   fcv = fgt || feq;
         CF_NE:   fcv = !feq;
         CF_EQ:   fcv = feq;
         CF_ORD:  fcv = !un;
         CF_UNO:  fcv = un;
         default: fcv = 1'b0;
      endcase

      // Status and address result.
      is_div = (req_data.op == OP_DIV) || (req_data.op == OP_REM) ||
               (req_data.op == OP_UDIV) || (req_data.op == OP_UREM);
      dzero  = req_data.wide ? (r == 64'd0) : (r[31:0] == 32'd0);
      ctrl_in.status  = ST_OK;
      ctrl_in.is_addr = 1'b0;
      ctrl_in.label   = 32'd0;
      if (req_data.op > OP_DCMP) begin
         ctrl_in.status = ST_NOFOLD;
      end else if (is_div && !ra && dzero) begin
         ctrl_in.status = ST_NOFOLD;
      end else if (req_data.op == OP_ADD) begin
         if (la && ra) begin
            ctrl_in.status = ST_ADDADDR;
         end else if (la) begin
            ctrl_in.is_addr = 1'b1;
            ctrl_in.label   = req_data.left_label;
         end else if (ra) begin
            ctrl_in.is_addr = 1'b1;
            ctrl_in.label   = req_data.right_label;
         end
      end else if (req_data.op == OP_SUB) begin
         if (la && !ra) begin
            ctrl_in.is_addr = 1'b1;
            ctrl_in.label   = req_data.left_label;
         end else if (la && ra && (req_data.left_label != req_data.right_label)) begin
            ctrl_in.status = ST_LABDIFF;
         end else if (!la && ra) begin
            ctrl_in.status = ST_NUMADDR;
         end
      end else if (la || ra) begin
         ctrl_in.status = (req_data.op == OP_ICMP && req_data.wide) ? ST_NOFOLD : ST_BADADDR;
      end
      if (ctrl_in.status == ST_OK) begin
         if (req_data.op == OP_ICMP && req_data.cond > CI_NE) begin
            ctrl_in.status = ST_NOFOLD;
         end else if ((req_data.op == OP_SCMP || req_data.op == OP_DCMP) &&
                      req_data.cond > CF_UNO) begin
            ctrl_in.status = ST_NOFOLD;
         end
      end

      // Operations computed in the decode stage.
      unique case (req_data.op)
         OP_ADD:   ctrl_in.value = l + r;
         OP_SUB:   ctrl_in.value = l - r;
         OP_AND:   ctrl_in.value = l & r;
         OP_OR:    ctrl_in.value = l | r;
         OP_XOR:   ctrl_in.value = l ^ r;
         OP_SAR:   ctrl_in.value = $signed(req_data.wide ? l : sx32(l)) >>> sh;
         OP_SHR:   ctrl_in.value = l >> sh;
         OP_SHL:   ctrl_in.value = l << sh;
         OP_EXTSB: ctrl_in.value = {{56{l[7]}}, l[7:0]};
         OP_EXTUB: ctrl_in.value = {56'd0, l[7:0]};
         OP_EXTSH: ctrl_in.value = {{48{l[15]}}, l[15:0]};
         OP_EXTUH: ctrl_in.value = {48'd0, l[15:0]};
         OP_EXTSW: ctrl_in.value = sx32(l);
         OP_EXTUW: ctrl_in.value = {32'd0, l[31:0]};
         OP_CAST:  ctrl_in.value = l;
         OP_ICMP:  ctrl_in.value = {63'd0, icv};
         OP_SCMP:  ctrl_in.value = {63'd0, fcv};
         OP_DCMP:  ctrl_in.value = {63'd0, fcv};
         default:  ctrl_in.value = 64'd0;
      endcase
      ctrl_in.op   = req_data.op;
      ctrl_in.wide = req_data.wide;

      // Divider operands: magnitudes for the signed forms.
      sa = req_data.wide ? l : sx32(l);
      sb = req_data.wide ? r : sx32(r);
      if (req_data.op == OP_DIV || req_data.op == OP_REM) begin
         div_in.num    = sa[63] ? 64'd0 - sa : sa;
         div_in.den    = sb[63] ? 64'd0 - sb : sb;
         ctrl_in.q_neg = sa[63] ^ sb[63];
         ctrl_in.r_neg = sa[63];
      end else begin
         div_in.num    = l;
         div_in.den    = r;
         ctrl_in.q_neg = 1'b0;
         ctrl_in.r_neg = 1'b0;
      end
      div_in.rem = 64'd0;

      // Multiplier partial products; only the low 64 bits are kept.
      pre_in.p0 = l[31:0] * r[31:0];
      pre_in.p1 = 32'(l[31:0] * r[63:32]);
      pre_in.p2 = 32'(l[63:32] * r[31:0]);

      // Float to integer: align the mantissa to bit 63 and shift by 63 - exponent.
      if (req_data.op == OP_STOSI) begin
         ef       = {3'd0, l[30:23]};
         mant     = {(l[30:23] != 8'd0), l[22:0], 40'd0};
         fspecial = l[30:23] == 8'hFF;
         ex       = $signed({2'b00, ef}) - 13'sd127;
         pre_in.fneg = l[31];
      end else begin
         ef       = l[62:52];
         mant     = {(l[62:52] != 11'd0), l[51:0], 11'd0};
         fspecial = l[62:52] == 11'h7FF;
         ex       = $signed({2'b00, ef}) - 13'sd1023;
         pre_in.fneg = l[63];
      end
      minv = req_data.wide ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
      fsh  = 6'(13'sd63 - ex);
      if (fspecial || ex >= (req_data.wide ? 13'sd63 : 13'sd31)) begin
         pre_in.fmag = minv;
         pre_in.fneg = 1'b0;
      end else if (ef == 11'd0 || ex < 13'sd0) begin
         pre_in.fmag = 64'd0;
      end else begin
         pre_in.fmag = mant >> fsh;
      end
   end

   // First divider stage also finishes the multiply and float conversion.
   always_comb begin
      ctrl_fix = ctrl_ff[0];
      if (ctrl_ff[0].op == OP_MUL) begin
         ctrl_fix.value = pre_ff.p0 + {pre_ff.p1 + pre_ff.p2, 32'd0};
      end else if (ctrl_ff[0].op == OP_STOSI || ctrl_ff[0].op == OP_DTOSI) begin
         ctrl_fix.value = pre_ff.fneg ? 64'd0 - pre_ff.fmag : pre_ff.fmag;
      end
   end

   // Decode stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
      end
      if (adv) begin
         ctrl_ff[0] <= ctrl_in;
         div_ff[0]  <= div_in;
         pre_ff     <= pre_in;
      end
   end

   // Divider stages: one quotient bit per stage, control travels alongside.
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (adv) begin
            div_ff[k]  <= div_step(div_ff[k-1]);
            ctrl_ff[k] <= (k == 1) ? ctrl_fix : ctrl_ff[k-1];
         end
      end
   end

   // Output stage: sign fix-up of divider results and final selection.
   always_comb begin : output_logic
      ctrl_type    c;
      logic [63:0] q;
      logic [63:0] rm;
      logic [63:0] sv;
      c  = ctrl_ff[DIV_STEPS];
      q  = div_ff[DIV_STEPS].num;
      rm = div_ff[DIV_STEPS].rem;
      if (c.op == OP_DIV) begin
         sv = c.q_neg ? 64'd0 - q : q;
      end else begin
         sv = c.r_neg ? 64'd0 - rm : rm;
      end
      if (!c.wide) begin
         sv = sx32(sv);
      end
      rsp_data_in.status = c.status;
      if (c.status != ST_OK) begin
         rsp_data_in.result_value   = 64'd0;
         rsp_data_in.result_is_addr = 1'b0;
         rsp_data_in.result_label   = 32'd0;
      end else begin
         unique case (c.op)
            OP_DIV, OP_REM: rsp_data_in.result_value = sv;
            OP_UDIV:        rsp_data_in.result_value = q;
            OP_UREM:        rsp_data_in.result_value = rm;
            default:        rsp_data_in.result_value = c.value;
         endcase
         rsp_data_in.result_is_addr = c.is_addr;
         rsp_data_in.result_label   = c.is_addr ? c.label : 32'd0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[DIV_STEPS];
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
